>>> sv/trr_pkg.sv
// ----------------------------------------------------------------------------
// trr_pkg
// Shared types and constants for the timer resolution rescale pipeline.
// ----------------------------------------------------------------------------
package trr_pkg;

  localparam int unsigned RES_W  = 30;
  localparam int unsigned SEC_W  = 32;
  localparam int unsigned TICK_W = 32;
  localparam int unsigned PROD_W = 2 * RES_W;

  localparam logic [31:0] NANOSEC = 32'd1000000000;

  localparam logic [1:0] MODE_ROUND_HALF = 2'd1;
  localparam logic [1:0] MODE_ROUND_UP   = 2'd2;

  // side data riding along the fold divider
  typedef struct packed {
    logic               err;
    logic [SEC_W-1:0]   secs;
    logic [TICK_W-1:0]  ticks;
    logic [RES_W-1:0]   target;
    logic [1:0]         mode;
  } fold_side_t;

  // side data riding along the rescale divider
  typedef struct packed {
    logic               err;
    logic [SEC_W-1:0]   secs;
    logic [TICK_W-1:0]  ticks;
    logic [RES_W-1:0]   target;
  } scale_side_t;

endpackage

>>> sv/timer_resolution_rescale.sv
// ----------------------------------------------------------------------------
// timer_resolution_rescale
// Folds excess ticks into seconds and rescales the remainder to a new
// tick resolution with truncation, round half up or round up.
// ----------------------------------------------------------------------------
// One request enters per cycle while in_stall is low; its path runs through
// a 31-stage bit-per-stage fold divider, a multiply stage, a bias-add stage,
// a 30-stage rescale divider and the output register. A stall on the
// result side holds the whole pipeline, so in_stall follows out_stall
// while a result waits.
module timer_resolution_rescale
  import trr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [SEC_W-1:0]   in_seconds_in,
  input  logic signed [TICK_W-1:0] in_ticks_in,
  input  logic [RES_W-1:0]   in_resolution_in,
  input  logic [31:0]        in_target_resolution,
  input  logic [1:0]         in_rounding_mode,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_status,
  output logic [SEC_W-1:0]   out_seconds_out,
  output logic [31:0]        out_ticks_out,
  output logic [31:0]        out_resolution_out
);

  logic         en;
  fold_side_t   side0;
  logic         f_v;
  logic [RES_W:0] f_quot;
  logic [RES_W-1:0] f_rem, f_den;
  fold_side_t   f_side;
  logic         m_v;
  logic [PROD_W-1:0] m_sum;
  logic [RES_W-1:0]  m_den;
  scale_side_t  m_side;
  logic         s_v;
  logic [RES_W-1:0] s_quot, s_rem, s_den;
  scale_side_t  s_side;

  logic              out_valid_r;
  logic              status_r;
  logic [SEC_W-1:0]  secs_r;
  logic [31:0]       ticks_r;
  logic [31:0]       res_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_comb begin
    side0.err    = (in_target_resolution > NANOSEC) || in_ticks_in[TICK_W-1]
                   || (in_resolution_in == '0);
    side0.secs   = in_seconds_in;
    side0.ticks  = in_ticks_in;
    side0.target = in_target_resolution[RES_W-1:0];
    side0.mode   = in_rounding_mode;
  end

  trr_div_pipe #(.NUM_W(RES_W + 1), .SIDE_W($bits(fold_side_t))) u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_valid && en),
    .rem_in   ('0),
    .num_in   (in_ticks_in[RES_W:0]),
    .den_in   (in_resolution_in),
    .side_in  (side0),
    .out_v    (f_v),
    .quot     (f_quot),
    .rem_out  (f_rem),
    .den_out  (f_den),
    .side_out (f_side)
  );

  trr_mul_stage u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (f_v),
    .fold_quot (f_quot),
    .fold_rem  (f_rem),
    .den_in    (f_den),
    .side_in   (f_side),
    .out_v     (m_v),
    .sum       (m_sum),
    .den_out   (m_den),
    .side_out  (m_side)
  );

  trr_div_pipe #(.NUM_W(RES_W), .SIDE_W($bits(scale_side_t))) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (m_v),
    .rem_in   (m_sum[PROD_W-1:RES_W]),
    .num_in   (m_sum[RES_W-1:0]),
    .den_in   (m_den),
    .side_in  (m_side),
    .out_v    (s_v),
    .quot     (s_quot),
    .rem_out  (s_rem),
    .den_out  (s_den),
    .side_out (s_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= s_side.err;
      secs_r   <= s_side.secs;
      if (s_side.err) begin
        ticks_r <= s_side.ticks;
        res_r   <= {2'b00, s_den};
      end else begin
        ticks_r <= {2'b00, s_quot};
        res_r   <= {2'b00, s_side.target};
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_seconds_out    = secs_r;
  assign out_ticks_out      = ticks_r;
  assign out_resolution_out = res_r;

  // rescaled ticks never exceed the target on success
  a_ticks_le_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_status) |-> (out_ticks_out <= out_resolution_out))
    else $error("rescaled ticks above target");

  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_status) |-> (out_resolution_out <= NANOSEC))
    else $error("target out of range on success");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_ticks_out)
                                  && $stable(s_v)))
    else $error("pipeline moved under stall");

  // the remainder stays below the divisor on success and never shows through
  a_rem_unused: assert property (@(posedge clk) disable iff (!rst_n)
    s_v |-> (s_rem < s_den || s_side.err))
    else $error("division remainder out of range");

endmodule

>>> sv/trr_div_pipe.sv
// ----------------------------------------------------------------------------
// trr_div_pipe
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module trr_div_pipe
  import trr_pkg::*;
#(
  parameter int unsigned NUM_W  = 31,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [RES_W-1:0]  rem_in,
  input  logic [NUM_W-1:0]  num_in,
  input  logic [RES_W-1:0]  den_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_v,
  output logic [NUM_W-1:0]  quot,
  output logic [RES_W-1:0]  rem_out,
  output logic [RES_W-1:0]  den_out,
  output logic [SIDE_W-1:0] side_out
);

  logic              v_r    [NUM_W];
  logic [RES_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  num_r  [NUM_W];
  logic [RES_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_st
    logic              v_i;
    logic [RES_W-1:0]  rem_i;
    logic [NUM_W-1:0]  num_i;
    logic [RES_W-1:0]  den_i;
    logic [SIDE_W-1:0] side_i;
    logic [RES_W:0]    trial;
    logic [RES_W:0]    diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign v_i    = in_v;
      assign rem_i  = rem_in;
      assign num_i  = num_in;
      assign den_i  = den_in;
      assign side_i = side_in;
    end else begin : g_next
      assign v_i    = v_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign num_i  = num_r[s-1];
      assign den_i  = den_r[s-1];
      assign side_i = side_r[s-1];
    end

    assign trial = {rem_i, num_i[NUM_W-1]};
    assign diff  = trial - {1'b0, den_i};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= ge ? diff[RES_W-1:0] : trial[RES_W-1:0];
        num_r[s]  <= {num_i[NUM_W-2:0], ge};
        den_r[s]  <= den_i;
        side_r[s] <= side_i;
      end
    end
  end

  assign out_v    = v_r[NUM_W-1];
  assign quot     = num_r[NUM_W-1];
  assign rem_out  = rem_r[NUM_W-1];
  assign den_out  = den_r[NUM_W-1];
  assign side_out = side_r[NUM_W-1];

endmodule

>>> sv/trr_mul_stage.sv
// ----------------------------------------------------------------------------
// trr_mul_stage
// Folds seconds, forms remainder times target, then adds the rounding bias.
// ----------------------------------------------------------------------------
module trr_mul_stage
  import trr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  logic [RES_W:0]     fold_quot,
  input  logic [RES_W-1:0]   fold_rem,
  input  logic [RES_W-1:0]   den_in,
  input  fold_side_t         side_in,
  output logic               out_v,
  output logic [PROD_W-1:0]  sum,
  output logic [RES_W-1:0]   den_out,
  output scale_side_t        side_out
);

  logic               v1_r, v2_r;
  logic [PROD_W-1:0]  prod_r;
  logic [RES_W-1:0]   bias_r;
  logic [RES_W-1:0]   den1_r, den2_r;
  scale_side_t        side1_r, side2_r;
  logic [PROD_W-1:0]  sum_r;
  logic [RES_W-1:0]   bias_nxt;
  logic [SEC_W-1:0]   secs_nxt;

  always_comb begin
    case (side_in.mode)
      MODE_ROUND_HALF: bias_nxt = den_in >> 1;
      MODE_ROUND_UP:   bias_nxt = den_in - RES_W'(1);
      default:         bias_nxt = '0;
    endcase
    secs_nxt = side_in.err ? side_in.secs
                           : side_in.secs + SEC_W'(fold_quot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r         <= fold_rem * side_in.target;
      bias_r         <= bias_nxt;
      den1_r         <= den_in;
      side1_r.err    <= side_in.err;
      side1_r.secs   <= secs_nxt;
      side1_r.ticks  <= side_in.ticks;
      side1_r.target <= side_in.target;
      sum_r          <= prod_r + PROD_W'(bias_r);
      den2_r         <= den1_r;
      side2_r        <= side1_r;
    end
  end

  assign out_v    = v2_r;
  assign sum      = sum_r;
  assign den_out  = den2_r;
  assign side_out = side2_r;

endmodule
